// ----- hw/rtl/chfb_pkg.sv -----
`default_nettype none

package chfb_pkg;

    // Default build values, handed down through the top level parameters
    localparam int CORDIC_STEPS_DEF        = 16;
    localparam int ANGLE_FRACTION_BITS_DEF = 7;

    // Arctangent table: atan(2^-i) in degrees, scaled by 2^16
    localparam int ATAN_LEN   = 24;
    localparam int ATAN_IW    = 5;
    localparam int ATAN_W     = 22;

    // Angle unit inside the datapath is 2^-16 degree
    localparam int DEG_FRAC   = 16;

    // Depth of the queue between the byte assembler and the CORDIC unit
    localparam int QUEUE_DEPTH = 2;

    // One assembled sample pair, passed from front to back
    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
    } t_pair;

    // Handshake between the assembler, the queue and the CORDIC unit
    typedef struct packed {
        logic push;
        logic pop;
    } t_q_ctrl;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic [ATAN_W-1:0] atan_deg(input logic [ATAN_IW-1:0] idx);
        logic [ATAN_W-1:0] v;
        begin
            case (idx)
                5'd0:    v = 22'd2949120;
                5'd1:    v = 22'd1740967;
                5'd2:    v = 22'd919879;
                5'd3:    v = 22'd466945;
                5'd4:    v = 22'd234379;
                5'd5:    v = 22'd117304;
                5'd6:    v = 22'd58666;
                5'd7:    v = 22'd29335;
                5'd8:    v = 22'd14668;
                5'd9:    v = 22'd7334;
                5'd10:   v = 22'd3667;
                5'd11:   v = 22'd1833;
                5'd12:   v = 22'd917;
                5'd13:   v = 22'd458;
                5'd14:   v = 22'd229;
                5'd15:   v = 22'd115;
                5'd16:   v = 22'd57;
                5'd17:   v = 22'd29;
                5'd18:   v = 22'd14;
                5'd19:   v = 22'd7;
                5'd20:   v = 22'd4;
                5'd21:   v = 22'd2;
                5'd22:   v = 22'd1;
                default: v = 22'd0;
            endcase
            return v;
        end
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/chfb_front.sv -----
`default_nettype none

module chfb_front
    import chfb_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_start_of_burst,
    output t_pair           o_pair,
    output logic            o_pair_valid
);

    localparam logic [2:0] POS_X_HI = 3'd0;
    localparam logic [2:0] POS_X_LO = 3'd1;
    localparam logic [2:0] POS_Y_HI = 3'd4;
    localparam logic [2:0] POS_Y_LO = 3'd5;

    logic [2:0]  r_pos,  n_pos;
    logic [15:0] r_x,    n_x;
    logic [7:0]  r_yh,   n_yh;
    logic [2:0]  pos;

    always_comb begin
        // restart on a start flag or an out-of-range position
        if (i_start_of_burst || (r_pos > POS_Y_LO)) begin
            pos = POS_X_HI;
        end else begin
            pos = r_pos;
        end
        n_pos = r_pos;
        n_x   = r_x;
        n_yh  = r_yh;
        if (i_accept) begin
            n_pos = pos + 3'd1;
            unique case (pos)
                POS_X_HI: n_x  = {i_data_byte, r_x[7:0]};
                POS_X_LO: n_x  = {r_x[15:8], i_data_byte};
                POS_Y_HI: n_yh = i_data_byte;
                POS_Y_LO: n_pos = POS_X_HI;
                default:  ;
            endcase
        end
    end

    assign o_pair_valid = i_accept && (pos == POS_Y_LO);
    assign o_pair.x     = r_x;
    assign o_pair.y     = {r_yh, i_data_byte};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_X_HI;
            r_x   <= '0;
            r_yh  <= '0;
        end else begin
            r_pos <= n_pos;
            r_x   <= n_x;
            r_yh  <= n_yh;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/chfb_queue.sv -----
`default_nettype none

module chfb_queue
    import chfb_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_q_ctrl i_ctrl,
    input  wire t_pair   i_wdata,
    output t_pair        o_rdata,
    output t_q_stat      o_stat
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_pair           r_mem [QUEUE_DEPTH];
    logic [PW-1:0]   r_wp, r_rp;
    logic [CW-1:0]   r_cnt;
    logic            do_push, do_pop;

    assign o_stat.full  = (r_cnt == CW'(QUEUE_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign do_push      = i_ctrl.push && !o_stat.full;
    assign do_pop       = i_ctrl.pop && !o_stat.empty;
    assign o_rdata      = r_mem[r_rp];

    // advance a pointer, wrapping at the queue depth
    function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
        begin
            if (p == PW'(QUEUE_DEPTH - 1)) begin
                return '0;
            end
            return p + PW'(1);
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= nxt(r_wp);
            end
            if (do_pop) begin
                r_rp <= nxt(r_rp);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/chfb_cordic.sv -----
`default_nettype none

module chfb_cordic
    import chfb_pkg::*;
#(
    parameter int CORDIC_STEPS        = CORDIC_STEPS_DEF,
    parameter int ANGLE_FRACTION_BITS = ANGLE_FRACTION_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_pair       i_pair,
    input  wire logic        i_pair_empty,
    output logic             o_pair_pop,
    input  wire logic        i_pop,
    output logic             o_empty,
    output logic [15:0]      o_heading,
    output logic signed [15:0] o_x_field,
    output logic signed [15:0] o_y_field
);

    localparam int STEPS = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
    localparam logic [ATAN_IW-1:0] LAST = ATAN_IW'(STEPS - 1);
    localparam int CW  = 27;   // rotation registers, input scaled by 2^8
    localparam int ZW  = 25;   // angle accumulator
    localparam int HW  = 27;   // angle plus offset
    localparam int RW  = 26;   // clamped angle plus rounding term
    localparam int SH  = DEG_FRAC - ANGLE_FRACTION_BITS;
    localparam logic signed [HW-1:0] H180 = HW'(180 * (2 ** DEG_FRAC));
    localparam logic signed [HW-1:0] H360 = HW'(360 * (2 ** DEG_FRAC));
    localparam logic [RW-1:0] HALF = RW'(2 ** (SH - 1));

    typedef enum logic [1:0] {S_IDLE, S_STEP, S_FIX, S_ROUND} t_state;

    t_state                 r_state;
    logic signed [CW-1:0]   r_x, r_y;
    logic signed [ZW-1:0]   r_z;
    logic signed [HW-1:0]   r_base;
    logic [ATAN_IW-1:0]     r_i;
    logic [RW-1:0]          r_h;
    logic signed [15:0]     r_xf, r_yf;
    logic                   r_out_valid;
    logic [15:0]            r_out_heading;
    logic signed [15:0]     r_out_x, r_out_y;

    logic signed [CW-1:0]   x_in, y_in, dx, dy;
    logic signed [ZW-1:0]   a;
    logic signed [HW-1:0]   h;
    logic [RW-1:0]          rs;
    logic [RW-1:0]          rq;
    logic                   y_pos;
    logic                   slot_free;

    assign o_pair_pop = (r_state == S_IDLE) && !i_pair_empty;
    assign slot_free  = !r_out_valid || i_pop;

    assign x_in = {{(CW-24){i_pair.x[15]}}, i_pair.x, 8'h00};
    assign y_in = {{(CW-24){i_pair.y[15]}}, i_pair.y, 8'h00};

    assign dx    = r_y >>> r_i;
    assign dy    = r_x >>> r_i;
    assign a     = ZW'(atan_deg(r_i));
    assign y_pos = !r_y[CW-1] && (r_y != '0);

    assign h  = r_base + HW'(r_z);
    assign rs = r_h + HALF;
    assign rq = rs >> SH;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // drop the slot on a pop unless the round step refills it at once
            if (i_pop && r_out_valid && (r_state != S_ROUND)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_pair_empty) begin
                        r_xf <= i_pair.x;
                        r_yf <= i_pair.y;
                        r_z  <= '0;
                        r_i  <= '0;
                        // fold the left half plane onto the right one
                        if (i_pair.x[15]) begin
                            r_x <= -x_in;
                            r_y <= -y_in;
                            r_base <= (!i_pair.y[15] || (i_pair.y == '0)) ? H360 : '0;
                        end else begin
                            r_x <= x_in;
                            r_y <= y_in;
                            r_base <= H180;
                        end
                        r_state <= (i_pair.y == '0) ? S_FIX : S_STEP;
                    end
                end
                S_STEP: begin
                    if (y_pos) begin
                        r_x <= r_x + dx;
                        r_y <= r_y - dy;
                        r_z <= r_z + a;
                    end else begin
                        r_x <= r_x - dx;
                        r_y <= r_y + dy;
                        r_z <= r_z - a;
                    end
                    r_i <= r_i + ATAN_IW'(1);
                    if (r_i == LAST) begin
                        r_state <= S_FIX;
                    end
                end
                S_FIX: begin
                    // clamp to the full circle
                    if (h[HW-1]) begin
                        r_h <= '0;
                    end else if (h > H360) begin
                        r_h <= RW'(H360);
                    end else begin
                        r_h <= RW'(h);
                    end
                    r_state <= S_ROUND;
                end
                S_ROUND: begin
                    if (slot_free) begin
                        r_out_valid   <= 1'b1;
                        r_out_heading <= (rq > RW'(16'hFFFF)) ? 16'hFFFF : rq[15:0];
                        r_out_x       <= r_xf;
                        r_out_y       <= r_yf;
                        r_state       <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_empty   = !r_out_valid;
    assign o_heading = r_out_heading;
    assign o_x_field = r_out_x;
    assign o_y_field = r_out_y;

endmodule

`default_nettype wire

// ----- hw/rtl/compass_heading_from_bytes.sv -----
`default_nettype none

// Channel   Direction  Handshake          Word
// bytes     in         i_push / o_full    i_data_byte, i_start_of_burst
// heading   out        o_empty / i_pop    o_heading, o_x_field, o_y_field
//
// A byte is taken in the cycle it is offered unless the pair queue is full.
// After the Y low byte is queued, the single shared rotation unit loads the
// pair, runs CORDIC_STEPS micro-rotations (at most 24), clamps the angle
// and rounds it to give the heading. A Y of zero skips the rotations.
// Reset is synchronous and clears the byte position, the queue and the
// result slot. A stalled result holds its slot while the CORDIC unit
// finishes the next pair and waits in its round step.

module compass_heading_from_bytes
    import chfb_pkg::*;
#(
    parameter int CORDIC_STEPS        = CORDIC_STEPS_DEF,
    parameter int ANGLE_FRACTION_BITS = ANGLE_FRACTION_BITS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    output logic               o_full,
    input  wire logic [7:0]    i_data_byte,
    input  wire logic          i_start_of_burst,
    output logic               o_empty,
    input  wire logic          i_pop,
    output logic [15:0]        o_heading,
    output logic signed [15:0] o_x_field,
    output logic signed [15:0] o_y_field
);

    t_pair   pair_in, pair_out;
    logic    pair_valid;
    logic    pair_pop;
    t_q_ctrl q_ctrl;
    t_q_stat q_stat;
    logic    accept;

    // hold off every byte while the queue has no room for a finished pair
    assign o_full = q_stat.full;
    assign accept = i_push && !q_stat.full;

    chfb_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_data_byte      (i_data_byte),
        .i_start_of_burst (i_start_of_burst),
        .o_pair           (pair_in),
        .o_pair_valid     (pair_valid)
    );

    assign q_ctrl.push = pair_valid;
    assign q_ctrl.pop  = pair_pop;

    chfb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (q_ctrl),
        .i_wdata (pair_in),
        .o_rdata (pair_out),
        .o_stat  (q_stat)
    );

    chfb_cordic #(
        .CORDIC_STEPS        (CORDIC_STEPS),
        .ANGLE_FRACTION_BITS (ANGLE_FRACTION_BITS)
    ) u_cordic (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pair       (pair_out),
        .i_pair_empty (q_stat.empty),
        .o_pair_pop   (pair_pop),
        .i_pop        (i_pop),
        .o_empty      (o_empty),
        .o_heading    (o_heading),
        .o_x_field    (o_x_field),
        .o_y_field    (o_y_field)
    );

endmodule

`default_nettype wire
